[rtl/core/point_in_tetrahedron_barycentric_unit_defines.svh]
// ----------------------------------------------------------------------------
// Point in tetrahedron unit - assertion macros
// Concurrent checks sampled on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TETRAHEDRON_BARYCENTRIC_UNIT_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_BARYCENTRIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PTB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptb check failed");
// Next-cycle implication.
`define PTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptb check failed");
`else
`define PTB_ASSERT_IMP(lbl, ante, cons)
`define PTB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// Widths, codes, latencies and shared types of the point in tetrahedron unit.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int IDX_W    = 12;
    localparam int COORD_W  = 32;
    localparam int TOL_W    = 16;
    localparam int WEIGHT_W = 32;

    localparam int NODE_DEPTH_DEF    = 4096;
    localparam int ELEMENT_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF     = 16;

    // Edge vectors are exact differences of two coordinates.
    localparam int EDGE_W = COORD_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int COF_W  = PROD_W + 1;
    // Cofactors are split into a low unsigned and a high signed part.
    localparam int LO_W   = 34;
    localparam int HI_W   = COF_W - LO_W;
    localparam int LP_W   = EDGE_W + LO_W + 1;
    localparam int HP_W   = EDGE_W + HI_W;
    // Determinants stay below 2^101 in magnitude.
    localparam int DET_W  = 104;
    localparam int Q_W    = 32;

    localparam int DET_LAT   = 8;
    localparam int RATIO_LAT = Q_W + 4;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic [1:0] {
        REQ_NODE    = 2'd0,
        REQ_ELEMENT = 2'd1,
        REQ_LOCATE  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_WRITE      = 2'd0,
        ST_ANSWER     = 2'd1,
        ST_DEGENERATE = 2'd2
    } status_t;

    typedef struct packed {
        logic query;
        logic elem_oor;
    } side_t;

    typedef struct packed {
        status_t                        status;
        logic                           enclosed;
        logic [3:0][WEIGHT_W-1:0]       weight;
    } res_t;

endpackage

[rtl/core/point_in_tetrahedron_barycentric_unit.sv]
// ----------------------------------------------------------------------------
// point_in_tetrahedron_barycentric_unit
// Node and element tables with a pipelined barycentric point locator.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  config    cfg_wr_en                cfg_wr_data (zero tolerance)
//  request   in_valid / in_ready      req_type .. vertex_d
//  result    out_valid / out_ready    status, inside_res, weight_a .. weight_d
//
//  One transaction is taken every cycle while in_ready is high; a result
//  reaches the output register through the element and vertex table reads
//  (the first on the accepting edge), the determinant pipeline, the divider
//  and the output register. The divider depth is set by its one quotient
//  bit per stage.
//  Reset clears control only; the tables need no clearing pass.
//  A result held at the output parks in a skid register, and in_ready drops
//  only while that register is full.
// ----------------------------------------------------------------------------
`include "point_in_tetrahedron_barycentric_unit_defines.svh"

module point_in_tetrahedron_barycentric_unit #(
    parameter int NODE_DEPTH    = ptb_pkg::NODE_DEPTH_DEF,
    parameter int ELEMENT_DEPTH = ptb_pkg::ELEMENT_DEPTH_DEF,
    parameter int FRAC_BITS     = ptb_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ptb_pkg::TOL_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [ptb_pkg::IDX_W-1:0]           node_index,
    input  logic [ptb_pkg::IDX_W-1:0]           element_index,
    input  logic signed [ptb_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [ptb_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [ptb_pkg::COORD_W-1:0]  coord_z,
    input  logic [ptb_pkg::IDX_W-1:0]           vertex_a,
    input  logic [ptb_pkg::IDX_W-1:0]           vertex_b,
    input  logic [ptb_pkg::IDX_W-1:0]           vertex_c,
    input  logic [ptb_pkg::IDX_W-1:0]           vertex_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic                                inside_res,
    output logic signed [ptb_pkg::WEIGHT_W-1:0] weight_a,
    output logic signed [ptb_pkg::WEIGHT_W-1:0] weight_b,
    output logic signed [ptb_pkg::WEIGHT_W-1:0] weight_c,
    output logic signed [ptb_pkg::WEIGHT_W-1:0] weight_d
);

    localparam int IW       = ptb_pkg::IDX_W;
    localparam int CRW      = ptb_pkg::COORD_W;
    localparam int NA_W     = $clog2(NODE_DEPTH);
    localparam int EA_W     = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
    localparam int SIDE_LAT = ptb_pkg::DET_LAT + ptb_pkg::RATIO_LAT;

    logic adv;
    logic acc;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;
    assign acc      = in_valid && adv;

    // Tolerance register.
    logic [ptb_pkg::TOL_W-1:0] zero_tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tolerance_reg <= ptb_pkg::TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            zero_tolerance_reg <= cfg_wr_data;
        end
    end

    // Table writes happen on the accepting edge, so later queries see them.
    logic node_we;
    logic elem_we;

    assign node_we = acc && (req_type == ptb_pkg::REQ_NODE) && (32'(node_index) < NODE_DEPTH);
    assign elem_we = acc && (req_type == ptb_pkg::REQ_ELEMENT)
                     && (32'(element_index) < ELEMENT_DEPTH);

    logic [4*IW-1:0] elem_rdata;

    ptb_ram #(
        .DEPTH (ELEMENT_DEPTH),
        .WIDTH (4 * IW)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (EA_W'(element_index)),
        .wdata ({vertex_d, vertex_c, vertex_b, vertex_a}),
        .re    (adv),
        .raddr (EA_W'(element_index)),
        .rdata (elem_rdata)
    );

    // Stage S1: element entry read.
    logic                 s1_valid_reg;
    ptb_pkg::side_t       s1_side_reg;
    logic signed [CRW-1:0] s1_pt_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid && (req_type != ptb_pkg::REQ_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.query    <= (req_type == ptb_pkg::REQ_LOCATE);
            s1_side_reg.elem_oor <= (32'(element_index) >= ELEMENT_DEPTH);
            s1_pt_reg[0]         <= coord_x;
            s1_pt_reg[1]         <= coord_y;
            s1_pt_reg[2]         <= coord_z;
        end
    end

    // Stage S2: the four vertex reads, one table copy each.
    logic [IW-1:0]    vtx [4];
    logic [3*CRW-1:0] node_rdata [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_node
        assign vtx[k] = elem_rdata[k*IW +: IW];

        ptb_ram #(
            .DEPTH (NODE_DEPTH),
            .WIDTH (3 * CRW)
        ) u_node_ram (
            .clk   (clk),
            .we    (node_we),
            .waddr (NA_W'(node_index)),
            .wdata ({coord_z, coord_y, coord_x}),
            .re    (adv),
            .raddr (NA_W'(vtx[k])),
            .rdata (node_rdata[k])
        );
    end

    logic                  s2_valid_reg;
    ptb_pkg::side_t        s2_side_reg;
    logic signed [CRW-1:0] s2_pt_reg [3];
    logic [3:0]            s2_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s1_side_reg;
            for (int j = 0; j < 3; j++)
            begin
                s2_pt_reg[j] <= s1_pt_reg[j];
            end
            for (int k = 0; k < 4; k++)
            begin
                s2_oor_reg[k] <= (32'(vtx[k]) >= NODE_DEPTH);
            end
        end
    end

    // A vertex index beyond the node table stands for the origin.
    logic signed [CRW-1:0] vert [4][3];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                vert[k][j] = s2_oor_reg[k] ? '0 : $signed(node_rdata[k][j*CRW +: CRW]);
            end
        end
    end

    logic signed [ptb_pkg::DET_W-1:0] vol;
    logic signed [ptb_pkg::DET_W-1:0] num [4];

    ptb_det u_det (
        .clk  (clk),
        .en   (adv),
        .vert (vert),
        .pt   (s2_pt_reg),
        .vol  (vol),
        .num  (num)
    );

    logic [ptb_pkg::WEIGHT_W-1:0] wgt [4];
    logic [3:0]                   wneg;
    logic [3:0]                   dz;

    for (genvar k = 0; k < 4; k++)
    begin : g_ratio
        ptb_ratio #(
            .FRAC_BITS (FRAC_BITS)
        ) u_ratio (
            .clk        (clk),
            .en         (adv),
            .num        (num[k]),
            .den        (vol),
            .tol        (zero_tolerance_reg),
            .weight     (wgt[k]),
            .weight_neg (wneg[k]),
            .den_zero   (dz[k])
        );
    end

    // Side information travels alongside the arithmetic.
    logic [SIDE_LAT-1:0] side_valid_reg;
    ptb_pkg::side_t      side_reg [SIDE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= '0;
        end
        else if (adv)
        begin
            side_valid_reg <= {side_valid_reg[SIDE_LAT-2:0], s2_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s2_side_reg;
            for (int i = 1; i < SIDE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Result assembly.
    logic           fin_valid;
    logic           fin_answer;
    ptb_pkg::res_t  fin_res;

    always_comb
    begin
        fin_valid  = side_valid_reg[SIDE_LAT-1];
        fin_answer = side_reg[SIDE_LAT-1].query && !side_reg[SIDE_LAT-1].elem_oor && !(|dz);
        if (!side_reg[SIDE_LAT-1].query)
        begin
            fin_res.status = ptb_pkg::ST_WRITE;
        end
        else if (fin_answer)
        begin
            fin_res.status = ptb_pkg::ST_ANSWER;
        end
        else
        begin
            fin_res.status = ptb_pkg::ST_DEGENERATE;
        end
        fin_res.enclosed = fin_answer && !(|wneg);
        for (int k = 0; k < 4; k++)
        begin
            fin_res.weight[k] = fin_answer ? wgt[k] : '0;
        end
    end

    // Output register with a skid stage behind it.
    logic          out_valid_reg;
    ptb_pkg::res_t out_res_reg;
    ptb_pkg::res_t skid_res_reg;
    logic          out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_valid;
            end
        end
        else if (adv && fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : fin_res;
        end
        else if (adv && fin_valid)
        begin
            skid_res_reg <= fin_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign inside_res = out_res_reg.enclosed;
    assign weight_a   = $signed(out_res_reg.weight[0]);
    assign weight_b   = $signed(out_res_reg.weight[1]);
    assign weight_c   = $signed(out_res_reg.weight[2]);
    assign weight_d   = $signed(out_res_reg.weight[3]);

    `PTB_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `PTB_ASSERT_IMP(a_inside_only_answer, out_valid_reg && out_res_reg.enclosed,
                    out_res_reg.status == ptb_pkg::ST_ANSWER)
    `PTB_ASSERT_IMP(a_blank_weights, out_valid_reg && (out_res_reg.status != ptb_pkg::ST_ANSWER),
                    out_res_reg.weight == '0)
    `PTB_ASSERT_NEXT(a_skid_fill, !skid_valid_reg && out_valid_reg && !out_ready && fin_valid,
                     skid_valid_reg)

endmodule

[rtl/core/ptb_ram.sv]
// ----------------------------------------------------------------------------
// ptb_ram
// Simple dual-port table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptb_ram #(
    parameter int DEPTH = ptb_pkg::NODE_DEPTH_DEF,
    parameter int WIDTH = 3 * ptb_pkg::COORD_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ptb_det.sv]
// ----------------------------------------------------------------------------
// ptb_det
// Eight-stage pipeline giving the volume determinant and the four weight
// numerators of a query point against a tetrahedron.
// ----------------------------------------------------------------------------
module ptb_det (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [ptb_pkg::COORD_W-1:0]      vert [4][3],
    input  logic signed [ptb_pkg::COORD_W-1:0]      pt   [3],
    output logic signed [ptb_pkg::DET_W-1:0]        vol,
    output logic signed [ptb_pkg::DET_W-1:0]        num  [4]
);

    localparam int EW  = ptb_pkg::EDGE_W;
    localparam int PW  = ptb_pkg::PROD_W;
    localparam int CW  = ptb_pkg::COF_W;
    localparam int LW  = ptb_pkg::LO_W;
    localparam int LPW = ptb_pkg::LP_W;
    localparam int HPW = ptb_pkg::HP_W;
    localparam int DW  = ptb_pkg::DET_W;

    // Stage 1: edges from vertex a and the query offset.
    logic signed [EW-1:0] e1_reg [3][3];
    logic signed [EW-1:0] q1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k][j] <= EW'(vert[k+1][j]) - EW'(vert[0][j]);
                end
                q1_reg[j] <= EW'(pt[j]) - EW'(vert[0][j]);
            end
        end
    end

    // Stage 2: products of the three cross pairs (c,d), (p,d), (c,p).
    logic signed [EW-1:0] vv [3][3];
    logic signed [EW-1:0] ww [3][3];
    logic signed [PW-1:0] p2_reg [3][6];
    logic signed [EW-1:0] a2_reg [3];
    logic signed [EW-1:0] q2_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            vv[0][j] = e1_reg[1][j];
            ww[0][j] = e1_reg[2][j];
            vv[1][j] = q1_reg[j];
            ww[1][j] = e1_reg[2][j];
            vv[2][j] = e1_reg[1][j];
            ww[2][j] = q1_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int pr = 0; pr < 3; pr++)
            begin
                p2_reg[pr][0] <= PW'(vv[pr][1]) * PW'(ww[pr][2]);
                p2_reg[pr][1] <= PW'(vv[pr][2]) * PW'(ww[pr][1]);
                p2_reg[pr][2] <= PW'(vv[pr][0]) * PW'(ww[pr][2]);
                p2_reg[pr][3] <= PW'(vv[pr][2]) * PW'(ww[pr][0]);
                p2_reg[pr][4] <= PW'(vv[pr][0]) * PW'(ww[pr][1]);
                p2_reg[pr][5] <= PW'(vv[pr][1]) * PW'(ww[pr][0]);
            end
            for (int j = 0; j < 3; j++)
            begin
                a2_reg[j] <= e1_reg[0][j];
                q2_reg[j] <= q1_reg[j];
            end
        end
    end

    // Stage 3: cofactors.
    logic signed [CW-1:0] t3_reg [3][3];
    logic signed [EW-1:0] a3_reg [3];
    logic signed [EW-1:0] q3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int pr = 0; pr < 3; pr++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    t3_reg[pr][c] <= CW'(p2_reg[pr][2*c]) - CW'(p2_reg[pr][2*c+1]);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                a3_reg[j] <= a2_reg[j];
                q3_reg[j] <= q2_reg[j];
            end
        end
    end

    // Stage 4: each 33 x 67 product is taken as two partial products.
    logic signed [EW-1:0]  ux [4][3];
    logic signed [CW-1:0]  tx [4][3];
    logic signed [LPW-1:0] lo4_reg [4][3];
    logic signed [HPW-1:0] hi4_reg [4][3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ux[0][j] = a3_reg[j];
            tx[0][j] = t3_reg[0][j];
            ux[1][j] = q3_reg[j];
            tx[1][j] = t3_reg[0][j];
            ux[2][j] = a3_reg[j];
            tx[2][j] = t3_reg[1][j];
            ux[3][j] = a3_reg[j];
            tx[3][j] = t3_reg[2][j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 4; d++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lo4_reg[d][j] <= LPW'(ux[d][j]) * LPW'($signed({1'b0, tx[d][j][LW-1:0]}));
                    hi4_reg[d][j] <= HPW'(ux[d][j]) * HPW'($signed(tx[d][j][CW-1:LW]));
                end
            end
        end
    end

    // Stage 5: recombine the partial products.
    logic signed [DW-1:0] term5_reg [4][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 4; d++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    term5_reg[d][j] <= (DW'(hi4_reg[d][j]) <<< LW) + DW'(lo4_reg[d][j]);
                end
            end
        end
    end

    // Stage 6: expansion along the first row.
    logic signed [DW-1:0] det6_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 4; d++)
            begin
                det6_reg[d] <= term5_reg[d][0] - term5_reg[d][1] + term5_reg[d][2];
            end
        end
    end

    // Stages 7 and 8: the numerator of vertex a is the volume less the others.
    logic signed [DW-1:0] s7a_reg;
    logic signed [DW-1:0] s7b_reg;
    logic signed [DW-1:0] det7_reg [4];
    logic signed [DW-1:0] na8_reg;
    logic signed [DW-1:0] det8_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7a_reg <= det6_reg[0] - det6_reg[1];
            s7b_reg <= det6_reg[2] + det6_reg[3];
            na8_reg <= s7a_reg - s7b_reg;
            for (int d = 0; d < 4; d++)
            begin
                det7_reg[d] <= det6_reg[d];
                det8_reg[d] <= det7_reg[d];
            end
        end
    end

    assign vol    = det8_reg[0];
    assign num[0] = na8_reg;
    assign num[1] = det8_reg[1];
    assign num[2] = det8_reg[2];
    assign num[3] = det8_reg[3];

endmodule

[rtl/core/ptb_ratio.sv]
// ----------------------------------------------------------------------------
// ptb_ratio
// Pipelined restoring divider: one weight, rounded to nearest with ties away
// from zero, saturated and cleared to zero within the tolerance.
// ----------------------------------------------------------------------------
module ptb_ratio #(
    parameter int FRAC_BITS = ptb_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [ptb_pkg::DET_W-1:0]      num,
    input  logic signed [ptb_pkg::DET_W-1:0]      den,
    input  logic        [ptb_pkg::TOL_W-1:0]      tol,
    output logic        [ptb_pkg::WEIGHT_W-1:0]   weight,
    output logic                                  weight_neg,
    output logic                                  den_zero
);

    localparam int DW = ptb_pkg::DET_W;
    localparam int QW = ptb_pkg::Q_W;
    localparam int RW = DW + FRAC_BITS + QW + 2;
    localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};

    // Stage 1: magnitudes and result sign.
    logic [DW-1:0] magn1_reg;
    logic [DW-1:0] magd1_reg;
    logic          neg1_reg;
    logic          dz1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magn1_reg <= num[DW-1] ? DW'(-num) : DW'(num);
            magd1_reg <= den[DW-1] ? DW'(-den) : DW'(den);
            neg1_reg  <= num[DW-1] ^ den[DW-1];
            dz1_reg   <= (den == '0);
        end
    end

    // Stage 2: dividend with the rounding half added, doubled divisor.
    logic [RW-1:0] x2_reg;
    logic [RW-1:0] y2_reg;
    logic          neg2_reg;
    logic          dz2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg   <= (RW'(magn1_reg) << (FRAC_BITS + 1)) + RW'(magd1_reg);
            y2_reg   <= RW'(magd1_reg) << 1;
            neg2_reg <= neg1_reg;
            dz2_reg  <= dz1_reg;
        end
    end

    // Stage 3 onwards: quotient bits, most significant first.
    logic [RW-1:0] rem_reg [QW+1];
    logic [RW-1:0] y_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          dz_reg  [QW+1];
    logic          ovf_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= x2_reg;
            y_reg[0]   <= y2_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg2_reg;
            dz_reg[0]  <= dz2_reg;
            ovf_reg[0] <= (x2_reg >= (y2_reg << QW));
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [RW-1:0] ysh;
        logic          ge;

        assign ysh = y_reg[s] << (QW - 1 - s);
        assign ge  = (rem_reg[s] >= ysh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? (rem_reg[s] - ysh) : rem_reg[s];
                y_reg[s+1]   <= y_reg[s];
                q_reg[s+1]   <= {q_reg[s][QW-2:0], ge};
                neg_reg[s+1] <= neg_reg[s];
                dz_reg[s+1]  <= dz_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    // Last stage: saturation and tolerance.
    logic [QW-1:0] lim;
    logic [QW-1:0] smag;
    logic          clear;
    logic [QW-1:0] weight_reg;
    logic          wneg_reg;
    logic          dzo_reg;

    always_comb
    begin
        lim   = neg_reg[QW] ? LIM_NEG : LIM_POS;
        smag  = (ovf_reg[QW] || (q_reg[QW] > lim)) ? lim : q_reg[QW];
        clear = (smag <= QW'(tol));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= clear ? '0 : (neg_reg[QW] ? (~smag + QW'(1)) : smag);
            wneg_reg   <= neg_reg[QW] && !clear;
            dzo_reg    <= dz_reg[QW];
        end
    end

    assign weight     = weight_reg;
    assign weight_neg = wneg_reg;
    assign den_zero   = dzo_reg;

endmodule
